// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Needs nothing else; simulation sees the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: check failed");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/arc_pkg.sv =====
// Types, widths and codes of the ARC replacement engine.
// Used by the channel interfaces and the core; depends on nothing.
`default_nettype none
package arc_pkg;
	localparam int ENTRY_SLOTS = 64;
	localparam int KEY_BITS    = 32;
	localparam int SLOT_W      = $clog2(ENTRY_SLOTS);
	localparam int LINK_W      = SLOT_W + 1;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRY_SLOTS);

	localparam int OP_W       = 2;
	localparam int KEY_IN_W   = 32;
	localparam int PAY_W      = 16;
	localparam int OUT_SLOT_W = 6;
	localparam int STATUS_W   = 3;
	localparam int CAP_W      = 24;
	localparam int OVH_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int WEIGHT_W   = 17;
	localparam int USERS_W    = 8;
	localparam int SUM_W      = 26;
	localparam int TARGET_W   = 25;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	typedef logic [1:0] list_t;
	localparam list_t L_T1 = 2'd0;
	localparam list_t L_B1 = 2'd1;
	localparam list_t L_T2 = 2'd2;
	localparam list_t L_B2 = 2'd3;

	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_FLUSH   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_GHOST   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 1'b1;
endpackage
`default_nettype wire

// ===== src/arc_req_if.sv =====
// Operation request channel of the ARC engine.
// Depends on arc_pkg for field widths.
`default_nettype none
interface arc_req_if;
	logic                       valid;
	logic                       ready;
	logic [arc_pkg::OP_W-1:0]     op;
	logic [arc_pkg::KEY_IN_W-1:0] key;
	logic [arc_pkg::PAY_W-1:0]    payload_bytes;
	modport source(output valid, op, key, payload_bytes, input ready);
	modport sink(input valid, op, key, payload_bytes, output ready);
endinterface
`default_nettype wire

// ===== src/arc_rsp_if.sv =====
// Result channel of the ARC engine.
// Depends on arc_pkg for field widths.
`default_nettype none
interface arc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [arc_pkg::OUT_SLOT_W-1:0] slot;
	logic [arc_pkg::STATUS_W-1:0]   status;
	modport source(output valid, hit, slot, status, input ready);
	modport sink(input valid, hit, slot, status, output ready);
endinterface
`default_nettype wire

// ===== src/arc_cfg_if.sv =====
// Register write channel of the ARC engine.
// Depends on arc_pkg for field widths.
`default_nettype none
interface arc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [arc_pkg::CFG_IDX_W-1:0]  index;
	logic [arc_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/arc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none
module arc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/adaptive_replacement_cache_policy_core.sv =====
// ARC replacement engine with byte-weighted lists: core sequencer.
// Depends on arc_pkg, the three channel interfaces, arc_ram and assert_macros.svh.
//
// Channels: req carries one operation (lookup, insert, release, flush) with its key
// and payload size; rsp returns one result (hit, slot, status) per operation; cfg
// writes capacity_bytes (index 0) and entry_overhead (index 1) and is always ready.
// Write cfg only while no operation is in flight.
// Sequence: every operation first scans all ENTRY_SLOTS entries one per cycle through
// the registered RAM read port, then runs its list moves. An unlink reads the entry,
// then rewrites its neighbours' links; a push writes the entry at a list head, then
// the old head's back link if any. A ghost hit adds the bit-serial divider for the
// target step and one replacement; an eviction scan unlinks each rotated entry and
// pushes it back to the head. Inserts with trimming run one or two evictions.
// req.ready is high only in the idle state, so one operation runs at a time.
// Reset: all slots free, lists empty, weights and target zero, registers at their
// defaults; no clearing pass is needed since slot valid bits live in flip-flops.
// Output stall: the result waits in an output register; the next request is taken
// meanwhile, and only its own completion waits for the register to drain.
`default_nettype none
`include "assert_macros.svh"
module adaptive_replacement_cache_policy_core (
	input  wire logic clk,
	input  wire logic arst_n,
	arc_req_if.sink   req,
	arc_rsp_if.source rsp,
	arc_cfg_if.sink   cfg
);
	import arc_pkg::*;

	localparam int STATE_W = 5;
	localparam logic [STATE_W-1:0] S_IDLE    = 5'd0;
	localparam logic [STATE_W-1:0] S_SCAN    = 5'd1;
	localparam logic [STATE_W-1:0] S_DISP    = 5'd2;
	localparam logic [STATE_W-1:0] S_LK_PUSH = 5'd3;
	localparam logic [STATE_W-1:0] S_LK_USR  = 5'd4;
	localparam logic [STATE_W-1:0] S_DIV     = 5'd5;
	localparam logic [STATE_W-1:0] S_DIVQ    = 5'd6;
	localparam logic [STATE_W-1:0] S_GH_FREE = 5'd7;
	localparam logic [STATE_W-1:0] S_GH_END  = 5'd8;
	localparam logic [STATE_W-1:0] S_IN_FREE = 5'd9;
	localparam logic [STATE_W-1:0] S_TRIM    = 5'd10;
	localparam logic [STATE_W-1:0] S_TRIM_RP = 5'd11;
	localparam logic [STATE_W-1:0] S_IN_ALLOC= 5'd12;
	localparam logic [STATE_W-1:0] S_FL_FREE = 5'd13;
	localparam logic [STATE_W-1:0] S_DONE    = 5'd14;
	localparam logic [STATE_W-1:0] S_U0      = 5'd15;
	localparam logic [STATE_W-1:0] S_U1      = 5'd16;
	localparam logic [STATE_W-1:0] S_P0      = 5'd17;
	localparam logic [STATE_W-1:0] S_P1      = 5'd18;
	localparam logic [STATE_W-1:0] S_RL0     = 5'd19;
	localparam logic [STATE_W-1:0] S_RL1     = 5'd20;
	localparam logic [STATE_W-1:0] S_RL2     = 5'd21;
	localparam logic [STATE_W-1:0] S_RL3     = 5'd22;
	localparam logic [STATE_W-1:0] S_RL4     = 5'd23;
	localparam logic [STATE_W-1:0] S_RP0     = 5'd24;
	localparam logic [STATE_W-1:0] S_RP1     = 5'd25;

	localparam int SEEN_W = SUM_W + 2;

	// Sequencer and return registers of the list subroutines
	logic [STATE_W-1:0] state_q, u_ret_q, p_ret_q, rl_ret_q, rp_ret_q;

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PAY_W-1:0]    pay_q;
	logic [LINK_W-1:0]   s_q, free_q, sc_q, t_q;
	logic [USERS_W-1:0]  su_q;
	list_t               sl_q;

	logic [SLOT_W-1:0]   u_slot_q, p_slot_q, h_q;
	logic [WEIGHT_W-1:0] ulw_q, p_w_q;
	list_t               p_list_q, rl_list_q;
	logic                rl_destroy_q, rl_ok_q, rp_second_q;
	logic [SEEN_W-1:0]   seen_q;
	logic [LINK_W-1:0]   rounds_q;

	logic [SUM_W-1:0]     dv_a_q, dv_b_q;
	logic [SUM_W:0]       dv_rem_q;
	logic [DIV_CNT_W-1:0] dv_cnt_q;
	logic                 dv_up_q;

	logic [TARGET_W-1:0] target_q;
	logic                itf_q;
	logic [CAP_W-1:0]    cap_q;
	logic [OVH_W-1:0]    ovh_q;

	logic [ENTRY_SLOTS-1:0] valid_q;
	logic [LINK_W-1:0]      head_q [4];
	logic [LINK_W-1:0]      tail_q [4];
	logic [SUM_W-1:0]       sum_q [4];

	logic                  res_hit_q, out_valid_q, out_hit_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [STATUS_W-1:0]   res_status_q, out_status_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;

	// RAM ports
	logic [SLOT_W-1:0]   raddr;
	logic                key_we, wt_we, usr_we, lst_we, prv_we, nxt_we;
	logic [SLOT_W-1:0]   key_wa, wt_wa, usr_wa, lst_wa, prv_wa, nxt_wa;
	logic [KEY_BITS-1:0] key_wd, key_rd;
	logic [WEIGHT_W-1:0] wt_wd, wt_rd;
	logic [USERS_W-1:0]  usr_wd, usr_rd;
	list_t               lst_wd, lst_rd;
	logic [LINK_W-1:0]   prv_wd, prv_rd, nxt_wd, nxt_rd;

	arc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRY_SLOTS)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(raddr), .rdata(key_rd));
	arc_ram #(.WIDTH(WEIGHT_W), .DEPTH(ENTRY_SLOTS)) u_wt_ram (
		.clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd), .raddr(raddr), .rdata(wt_rd));
	arc_ram #(.WIDTH(USERS_W), .DEPTH(ENTRY_SLOTS)) u_usr_ram (
		.clk(clk), .we(usr_we), .waddr(usr_wa), .wdata(usr_wd), .raddr(raddr), .rdata(usr_rd));
	arc_ram #(.WIDTH(2), .DEPTH(ENTRY_SLOTS)) u_lst_ram (
		.clk(clk), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd), .raddr(raddr), .rdata(lst_rd));
	arc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRY_SLOTS)) u_prv_ram (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(raddr), .rdata(prv_rd));
	arc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRY_SLOTS)) u_nxt_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(raddr), .rdata(nxt_rd));

	function automatic logic [LINK_W-1:0] lower_slot(input logic [LINK_W-1:0] a,
			input logic [SLOT_W-1:0] b);
		logic [LINK_W-1:0] bx;
		bx = {1'b0, b};
		return (bx < a) ? bx : a;
	endfunction

	// Combinational helpers
	logic                req_acc;
	logic [LINK_W-1:0]   sc_prev;
	logic                s_found, s_resident;
	logic [SUM_W-1:0]    rl_sum;
	logic                rl_rot, rl_fail;
	logic [TARGET_W-1:0] thr;
	logic [WEIGHT_W-1:0] ghost_w, new_w;
	logic [LINK_W-1:0]   p_head;
	logic [SUM_W:0]      dv_sh;
	logic                dv_ge;
	logic [SUM_W-1:0]    dv_q;
	logic [SUM_W:0]      tgt_up;
	logic [SUM_W:0]      t1b1;
	logic [SUM_W+1:0]    all_w;
	logic [SUM_W+1:0]    cap_x;
	logic                ht_ok;

	assign req_acc    = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_valid_q;
	assign rsp.hit    = out_hit_q;
	assign rsp.slot   = out_slot_q;
	assign rsp.status = out_status_q;

	assign sc_prev    = sc_q - LINK_W'(1);
	assign s_found    = (s_q != NIL);
	assign s_resident = (sl_q == L_T1) || (sl_q == L_T2);
	assign rl_sum     = sum_q[rl_list_q];
	assign rl_rot     = (t_q != NIL) && (usr_rd != '0) && (SEEN_W'(rl_sum) > seen_q)
		&& (rounds_q < LINK_W'(ENTRY_SLOTS));
	assign rl_fail    = (t_q == NIL) || (usr_rd != '0) || (seen_q >= SEEN_W'(rl_sum));
	assign thr        = (target_q > TARGET_W'(1)) ? target_q : TARGET_W'(1);
	assign ghost_w    = (WEIGHT_W'(ovh_q) < ulw_q) ? WEIGHT_W'(ovh_q) : ulw_q;
	assign new_w      = WEIGHT_W'(pay_q) + WEIGHT_W'(ovh_q);
	assign p_head     = head_q[p_list_q];
	assign dv_sh      = {dv_rem_q[SUM_W-1:0], dv_a_q[SUM_W-1]};
	assign dv_ge      = (dv_sh >= {1'b0, dv_b_q});
	assign dv_q       = (dv_a_q == '0) ? SUM_W'(1) : dv_a_q;
	assign tgt_up     = (SUM_W+1)'(target_q) + (SUM_W+1)'(dv_q);
	assign t1b1       = (SUM_W+1)'(sum_q[L_T1]) + (SUM_W+1)'(sum_q[L_B1]);
	assign all_w      = (SUM_W+2)'(t1b1) + (SUM_W+2)'(sum_q[L_T2]) + (SUM_W+2)'(sum_q[L_B2]);
	assign cap_x      = (SUM_W+2)'(cap_q);
	assign ht_ok      = ((head_q[0] == NIL) == (tail_q[0] == NIL))
		&& ((head_q[1] == NIL) == (tail_q[1] == NIL))
		&& ((head_q[2] == NIL) == (tail_q[2] == NIL))
		&& ((head_q[3] == NIL) == (tail_q[3] == NIL));

	// RAM read address and write ports, driven from the sequencer state
	always_comb begin
		raddr  = '0;
		key_we = 1'b0; key_wa = '0; key_wd = key_q;
		wt_we  = 1'b0; wt_wa  = '0; wt_wd  = new_w;
		usr_we = 1'b0; usr_wa = '0; usr_wd = '0;
		lst_we = 1'b0; lst_wa = '0; lst_wd = p_list_q;
		prv_we = 1'b0; prv_wa = '0; prv_wd = NIL;
		nxt_we = 1'b0; nxt_wa = '0; nxt_wd = NIL;
		case (state_q)
			S_SCAN: begin
				raddr = sc_q[SLOT_W-1:0];
			end
			S_U0: begin
				raddr = u_slot_q;
			end
			S_RL0: begin
				raddr = tail_q[rl_list_q][SLOT_W-1:0];
			end
			S_U1: begin
				prv_we = (nxt_rd != NIL);
				prv_wa = nxt_rd[SLOT_W-1:0];
				prv_wd = prv_rd;
				nxt_we = (prv_rd != NIL);
				nxt_wa = prv_rd[SLOT_W-1:0];
				nxt_wd = nxt_rd;
			end
			S_P0: begin
				lst_we = 1'b1;
				lst_wa = p_slot_q;
				prv_we = 1'b1;
				prv_wa = p_slot_q;
				prv_wd = NIL;
				nxt_we = 1'b1;
				nxt_wa = p_slot_q;
				nxt_wd = p_head;
			end
			S_P1: begin
				prv_we = 1'b1;
				prv_wa = h_q;
				prv_wd = {1'b0, p_slot_q};
			end
			S_DISP: begin
				// release: drop one user of a resident entry
				usr_we = (op_q == OP_RELEASE) && s_found && s_resident && (su_q != '0);
				usr_wa = s_q[SLOT_W-1:0];
				usr_wd = su_q - USERS_W'(1);
			end
			S_LK_USR: begin
				usr_we = 1'b1;
				usr_wa = s_q[SLOT_W-1:0];
				usr_wd = (su_q == '1) ? su_q : su_q + USERS_W'(1);
			end
			S_RP1: begin
				wt_we = rl_ok_q;
				wt_wa = t_q[SLOT_W-1:0];
				wt_wd = ghost_w;
			end
			S_IN_ALLOC: begin
				key_we = (free_q != NIL);
				key_wa = free_q[SLOT_W-1:0];
				wt_we  = (free_q != NIL);
				wt_wa  = free_q[SLOT_W-1:0];
				usr_we = (free_q != NIL);
				usr_wa = free_q[SLOT_W-1:0];
				usr_wd = USERS_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
				sum_q[i]  <= '0;
			end
			target_q     <= '0;
			itf_q        <= 1'b0;
			cap_q        <= CAP_W'(65536);
			ovh_q        <= OVH_W'(24);
			out_valid_q  <= 1'b0;
			rounds_q     <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_CAPACITY: cap_q <= cfg.data;
					CFG_OVERHEAD: ovh_q <= cfg.data[OVH_W-1:0];
					default: begin
					end
				endcase
			end
			// drop the transfer unless a new result loads the register this cycle
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						op_q         <= req.op;
						key_q        <= KEY_BITS'(req.key);
						pay_q        <= req.payload_bytes;
						sc_q         <= '0;
						s_q          <= NIL;
						free_q       <= NIL;
						res_hit_q    <= 1'b0;
						res_slot_q   <= '0;
						res_status_q <= ST_OK;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// compare the entry read last cycle, note the lowest free slot
					if (sc_q != '0 && valid_q[sc_prev[SLOT_W-1:0]] && key_rd == key_q) begin
						s_q  <= sc_prev;
						su_q <= usr_rd;
						sl_q <= lst_rd;
					end
					if (sc_q != NIL && !valid_q[sc_q[SLOT_W-1:0]] && free_q == NIL) begin
						free_q <= sc_q;
					end
					if (sc_q == NIL) begin
						state_q <= S_DISP;
					end else begin
						sc_q <= sc_q + LINK_W'(1);
					end
				end
				S_DISP: begin
					case (op_q)
						OP_LOOKUP: begin
							if (!s_found) begin
								itf_q        <= 1'b0;
								res_status_q <= ST_MISS;
								state_q      <= S_DONE;
							end else if (s_resident) begin
								u_slot_q <= s_q[SLOT_W-1:0];
								u_ret_q  <= S_LK_PUSH;
								state_q  <= S_U0;
							end else begin
								dv_up_q  <= (sl_q == L_B1);
								dv_a_q   <= (sl_q == L_B1) ? sum_q[L_B2] : sum_q[L_B1];
								dv_b_q   <= (sl_q == L_B1) ? sum_q[L_B1] : sum_q[L_B2];
								dv_rem_q <= '0;
								dv_cnt_q <= '0;
								state_q  <= S_DIV;
							end
						end
						OP_INSERT: begin
							if (s_found) begin
								u_slot_q <= s_q[SLOT_W-1:0];
								u_ret_q  <= S_IN_FREE;
								state_q  <= S_U0;
							end else begin
								state_q  <= S_IN_FREE;
							end
						end
						OP_RELEASE: begin
							if (!s_found || !s_resident) begin
								res_status_q <= ST_ABSENT;
							end
							state_q <= S_DONE;
						end
						OP_FLUSH: begin
							if (!s_found) begin
								res_status_q <= ST_ABSENT;
								state_q      <= S_DONE;
							end else begin
								u_slot_q <= s_q[SLOT_W-1:0];
								u_ret_q  <= S_FL_FREE;
								state_q  <= S_U0;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_LK_PUSH: begin
					p_slot_q <= s_q[SLOT_W-1:0];
					p_list_q <= L_T2;
					p_w_q    <= ulw_q;
					p_ret_q  <= S_LK_USR;
					state_q  <= S_P0;
				end
				S_LK_USR: begin
					res_hit_q  <= 1'b1;
					res_slot_q <= s_q[SLOT_W-1:0];
					state_q    <= S_DONE;
				end
				S_DIV: begin
					if (dv_b_q == '0) begin
						dv_a_q  <= SUM_W'(1);
						state_q <= S_DIVQ;
					end else begin
						// one restoring step per cycle, quotient shifts into dv_a_q
						dv_rem_q <= dv_ge ? dv_sh - {1'b0, dv_b_q} : dv_sh;
						dv_a_q   <= {dv_a_q[SUM_W-2:0], dv_ge};
						if (dv_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
							state_q <= S_DIVQ;
						end else begin
							dv_cnt_q <= dv_cnt_q + DIV_CNT_W'(1);
						end
					end
				end
				S_DIVQ: begin
					if (dv_up_q) begin
						target_q <= (tgt_up > (SUM_W+1)'(cap_q)) ? TARGET_W'(cap_q)
							: tgt_up[TARGET_W-1:0];
					end else begin
						target_q <= (SUM_W'(target_q) > dv_q)
							? TARGET_W'(SUM_W'(target_q) - dv_q) : '0;
					end
					u_slot_q <= s_q[SLOT_W-1:0];
					u_ret_q  <= S_GH_FREE;
					state_q  <= S_U0;
				end
				S_GH_FREE: begin
					valid_q[s_q[SLOT_W-1:0]] <= 1'b0;
					free_q   <= lower_slot(free_q, s_q[SLOT_W-1:0]);
					rp_ret_q <= S_GH_END;
					state_q  <= S_RP0;
				end
				S_GH_END: begin
					itf_q        <= 1'b1;
					res_status_q <= ST_GHOST;
					state_q      <= S_DONE;
				end
				S_IN_FREE: begin
					if (s_found) begin
						valid_q[s_q[SLOT_W-1:0]] <= 1'b0;
						free_q <= lower_slot(free_q, s_q[SLOT_W-1:0]);
					end
					state_q <= itf_q ? S_IN_ALLOC : S_TRIM;
				end
				S_TRIM: begin
					seen_q       <= '0;
					rounds_q     <= '0;
					rl_destroy_q <= 1'b1;
					if (t1b1 >= (SUM_W+1)'(cap_q)) begin
						if (SUM_W'(cap_q) > sum_q[L_T1]) begin
							rl_list_q <= L_B1;
							rl_ret_q  <= S_TRIM_RP;
						end else begin
							rl_list_q <= L_T1;
							rl_ret_q  <= S_IN_ALLOC;
						end
						state_q <= S_RL0;
					end else if (all_w >= cap_x) begin
						if (all_w >= (cap_x << 1)) begin
							rl_list_q <= L_B2;
							rl_ret_q  <= S_TRIM_RP;
							state_q   <= S_RL0;
						end else begin
							state_q   <= S_TRIM_RP;
						end
					end else begin
						state_q <= S_IN_ALLOC;
					end
				end
				S_TRIM_RP: begin
					rp_ret_q <= S_IN_ALLOC;
					state_q  <= S_RP0;
				end
				S_IN_ALLOC: begin
					if (free_q == NIL) begin
						res_status_q <= ST_NO_SLOT;
						state_q      <= S_DONE;
					end else begin
						p_slot_q   <= free_q[SLOT_W-1:0];
						p_list_q   <= itf_q ? L_T2 : L_T1;
						p_w_q      <= new_w;
						p_ret_q    <= S_DONE;
						res_slot_q <= free_q[SLOT_W-1:0];
						state_q    <= S_P0;
					end
				end
				S_FL_FREE: begin
					valid_q[s_q[SLOT_W-1:0]] <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_hit_q    <= res_hit_q;
						out_slot_q   <= OUT_SLOT_W'(res_slot_q);
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				S_U0: begin
					state_q <= S_U1;
				end
				S_U1: begin
					if (prv_rd == NIL) begin
						head_q[lst_rd] <= nxt_rd;
					end
					if (nxt_rd == NIL) begin
						tail_q[lst_rd] <= prv_rd;
					end
					sum_q[lst_rd] <= sum_q[lst_rd] - SUM_W'(wt_rd);
					ulw_q   <= wt_rd;
					state_q <= u_ret_q;
				end
				S_P0: begin
					head_q[p_list_q] <= {1'b0, p_slot_q};
					if (tail_q[p_list_q] == NIL) begin
						tail_q[p_list_q] <= {1'b0, p_slot_q};
					end
					sum_q[p_list_q]   <= sum_q[p_list_q] + SUM_W'(p_w_q);
					valid_q[p_slot_q] <= 1'b1;
					h_q     <= p_head[SLOT_W-1:0];
					state_q <= (p_head != NIL) ? S_P1 : p_ret_q;
				end
				S_P1: begin
					state_q <= p_ret_q;
				end
				S_RL0: begin
					t_q     <= tail_q[rl_list_q];
					state_q <= S_RL1;
				end
				S_RL1: begin
					if (rl_rot) begin
						// entry still in use: rotate it to the MRU end
						u_slot_q <= t_q[SLOT_W-1:0];
						u_ret_q  <= S_RL2;
						state_q  <= S_U0;
					end else if (rl_fail) begin
						rl_ok_q <= 1'b0;
						state_q <= rl_ret_q;
					end else begin
						u_slot_q <= t_q[SLOT_W-1:0];
						u_ret_q  <= S_RL4;
						state_q  <= S_U0;
					end
				end
				S_RL2: begin
					p_slot_q <= t_q[SLOT_W-1:0];
					p_list_q <= rl_list_q;
					p_w_q    <= ulw_q;
					p_ret_q  <= S_RL3;
					state_q  <= S_P0;
				end
				S_RL3: begin
					seen_q   <= seen_q + SEEN_W'(ulw_q);
					rounds_q <= rounds_q + LINK_W'(1);
					state_q  <= S_RL0;
				end
				S_RL4: begin
					if (rl_destroy_q) begin
						valid_q[t_q[SLOT_W-1:0]] <= 1'b0;
						free_q  <= lower_slot(free_q, t_q[SLOT_W-1:0]);
						rl_ok_q <= 1'b0;
					end else begin
						rl_ok_q <= 1'b1;
					end
					state_q <= rl_ret_q;
				end
				S_RP0: begin
					rl_list_q    <= (sum_q[L_T1] >= SUM_W'(thr)) ? L_T1 : L_T2;
					rl_destroy_q <= 1'b0;
					rl_ret_q     <= S_RP1;
					rp_second_q  <= 1'b0;
					seen_q       <= '0;
					rounds_q     <= '0;
					state_q      <= S_RL0;
				end
				S_RP1: begin
					if (rl_ok_q) begin
						// demote to the matching ghost list with the trimmed weight
						p_slot_q <= t_q[SLOT_W-1:0];
						p_list_q <= rl_list_q + list_t'(1);
						p_w_q    <= ghost_w;
						p_ret_q  <= rp_ret_q;
						state_q  <= S_P0;
					end else if (!rp_second_q) begin
						rp_second_q <= 1'b1;
						rl_list_q   <= rl_list_q ^ L_T2;
						seen_q      <= '0;
						rounds_q    <= '0;
						state_q     <= S_RL0;
					end else begin
						state_q <= rp_ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_head_tail_pair, clk, arst_n, ht_ok)
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_acc, !req.ready)
	`ASSERT_ALWAYS(a_rounds_bound, clk, arst_n, rounds_q <= LINK_W'(ENTRY_SLOTS))
	`ASSERT_NEXT(a_result_from_done, clk, arst_n, !out_valid_q && state_q != S_DONE, !out_valid_q)
endmodule
`default_nettype wire

// ===== sim/arc_tb_if.sv =====
// Item and result record types of the ARC engine testbench.
// Stands alone; the channel interfaces come from src.
`default_nettype none
package arc_tb_types;
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
		logic [15:0] payload_bytes;
	} arc_op_t;
	typedef struct packed {
		logic       hit;
		logic [5:0] slot;
		logic [2:0] status;
	} arc_res_t;
endpackage
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the byte-weighted ARC replacement engine.
// Drives random and directed operations, predicts each result with a local list model.
// Depends on arc_pkg, arc_tb_types and the req, rsp and cfg channel interfaces.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import arc_pkg::*;
	import arc_tb_types::*;

	localparam int NSLOT = 64;
	localparam int LIMIT = 20_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arc_req_if req();
	arc_rsp_if rsp();
	arc_cfg_if cfg();

	adaptive_replacement_cache_policy_core dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cache model
	longint unsigned cap_bytes, ovh_bytes;
	logic [31:0] m_key[NSLOT];
	int unsigned m_weight[NSLOT];
	int unsigned m_users[NSLOT];
	int unsigned m_tag[NSLOT];
	int m_prev[NSLOT], m_next[NSLOT];
	int m_head[4], m_tail[4];
	longint unsigned m_sum[4];
	longint unsigned m_target;
	bit m_to_freq;

	arc_op_t pending_ops[$];
	arc_res_t expected_res[$];
	int errors = 0;
	longint cycles = 0;
	bit no_idle = 1'b0;
	int hold_off = 0;

	function automatic void model_reset();
		for (int s = 0; s < NSLOT; s++) m_tag[s] = 0;
		for (int l = 0; l < 4; l++) begin
			m_head[l] = NSLOT; m_tail[l] = NSLOT; m_sum[l] = 0;
		end
		m_target = 0; m_to_freq = 0;
		cap_bytes = 65536; ovh_bytes = 24;
	endfunction

	function automatic void unlink(int s);
		int l, p, n;
		l = (m_tag[s] - 1) & 3;
		p = m_prev[s]; n = m_next[s];
		if (p != NSLOT) m_next[p] = n; else m_head[l] = n;
		if (n != NSLOT) m_prev[n] = p; else m_tail[l] = p;
		m_sum[l] -= m_weight[s];
	endfunction

	function automatic void push_head(int l, int s);
		int h;
		h = m_head[l];
		m_prev[s] = NSLOT; m_next[s] = h;
		if (h != NSLOT) m_prev[h] = s;
		m_head[l] = s;
		if (m_tail[l] == NSLOT) m_tail[l] = s;
		m_sum[l] += m_weight[s];
		m_tag[s] = l + 1;
	endfunction

	function automatic int evict_lru(int l, bit destroy);
		longint unsigned seen;
		int rounds, t;
		seen = 0; rounds = 0;
		while (m_tail[l] != NSLOT && m_users[m_tail[l]] != 0 && seen < m_sum[l]
				&& rounds < NSLOT) begin
			t = m_tail[l];
			unlink(t);
			push_head(l, t);
			seen += m_weight[t];
			rounds++;
		end
		t = m_tail[l];
		if (t == NSLOT || m_users[t] != 0 || seen >= m_sum[l]) return NSLOT;
		unlink(t);
		if (destroy) begin
			m_tag[t] = 0;
			return NSLOT;
		end
		return t;
	endfunction

	function automatic bit demote(int from, int to);
		int t;
		t = evict_lru(from, 1'b0);
		if (t == NSLOT) return 1'b0;
		if (ovh_bytes < m_weight[t]) m_weight[t] = ovh_bytes;
		push_head(to, t);
		return 1'b1;
	endfunction

	function automatic void replace_one();
		longint unsigned thr;
		thr = m_target > 1 ? m_target : 1;
		if (m_sum[L_T1] >= thr) begin
			if (!demote(L_T1, L_B1)) void'(demote(L_T2, L_B2));
		end else begin
			if (!demote(L_T2, L_B2)) void'(demote(L_T1, L_B1));
		end
	endfunction

	function automatic void trim_recent();
		longint unsigned t1b1, all;
		t1b1 = m_sum[L_T1] + m_sum[L_B1];
		all = t1b1 + m_sum[L_T2] + m_sum[L_B2];
		if (t1b1 >= cap_bytes) begin
			if (m_sum[L_T1] < cap_bytes) begin
				void'(evict_lru(L_B1, 1'b1));
				replace_one();
			end else void'(evict_lru(L_T1, 1'b1));
		end else if (all >= cap_bytes) begin
			if (all >= 2 * cap_bytes) void'(evict_lru(L_B2, 1'b1));
			replace_one();
		end
	endfunction

	function automatic arc_res_t predict_arc(arc_op_t it);
		arc_res_t r;
		int s, tag;
		longint unsigned q, b1, b2;
		r = '0;
		s = NSLOT;
		for (int i = 0; i < NSLOT; i++)
			if (s == NSLOT && m_tag[i] != 0 && m_key[i] == it.key) s = i;
		case (it.op)
			OP_LOOKUP: begin
				if (s == NSLOT) begin
					m_to_freq = 0; r.status = ST_MISS;
				end else begin
					tag = m_tag[s];
					if (tag == 1 || tag == 3) begin
						unlink(s); push_head(L_T2, s);
						if (m_users[s] < 255) m_users[s]++;
						r.hit = 1'b1; r.slot = s[5:0];
					end else begin
						b1 = m_sum[L_B1]; b2 = m_sum[L_B2];
						if (tag == 2) begin
							q = b1 != 0 ? b2 / b1 : 1;
							if (q < 1) q = 1;
							m_target += q;
							if (m_target > cap_bytes) m_target = cap_bytes;
						end else begin
							q = b2 != 0 ? b1 / b2 : 1;
							if (q < 1) q = 1;
							m_target = m_target > q ? m_target - q : 0;
						end
						unlink(s); m_tag[s] = 0;
						replace_one();
						m_to_freq = 1; r.status = ST_GHOST;
					end
				end
			end
			OP_INSERT: begin
				if (s != NSLOT) begin
					unlink(s); m_tag[s] = 0;
				end
				if (!m_to_freq) trim_recent();
				s = 0;
				while (s < NSLOT && m_tag[s] != 0) s++;
				if (s == NSLOT) r.status = ST_NO_SLOT;
				else begin
					m_key[s] = it.key;
					m_weight[s] = it.payload_bytes + ovh_bytes;
					m_users[s] = 1;
					push_head(m_to_freq ? L_T2 : L_T1, s);
					r.slot = s[5:0];
				end
			end
			OP_RELEASE: begin
				if (s == NSLOT || (m_tag[s] != 1 && m_tag[s] != 3)) r.status = ST_ABSENT;
				else if (m_users[s] != 0) m_users[s]--;
			end
			default: begin
				if (s == NSLOT) r.status = ST_ABSENT;
				else begin
					unlink(s); m_tag[s] = 0;
				end
			end
		endcase
		return r;
	endfunction

	// request driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= '0; req.key <= '0; req.payload_bytes <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_res.push_back(predict_arc(
					arc_op_t'{req.op, req.key, req.payload_bytes}));
				void'(pending_ops.pop_front());
			end
			if (!(req.valid && !req.ready)) begin
				if ((req.valid && req.ready) && !no_idle && $urandom_range(0, 9) == 0) begin
					req.valid <= 1'b0;
					send_gap <= $urandom_range(1, 15);
				end else begin
					if (send_gap > 0) send_gap <= send_gap - 1;
					if (send_gap <= 1 && pending_ops.size() > 0) begin
						arc_op_t nx;
						nx = pending_ops[0];
						req.valid <= 1'b1;
						req.op <= nx.op; req.key <= nx.key; req.payload_bytes <= nx.payload_bytes;
					end else req.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted down on its own
	always @(posedge clk) begin
		if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// result monitor with receiver stalls
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			cycles++;
			if (rsp.valid && rsp.ready) begin
				if (expected_res.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result hit=%0d slot=%0d status=%0d",
						rsp.hit, rsp.slot, rsp.status);
				end else begin
					arc_res_t e;
					e = expected_res.pop_front();
					if (e.hit !== rsp.hit || e.slot !== rsp.slot || e.status !== rsp.status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp hit=%0d slot=%0d status=%0d got %0d %0d %0d",
								e.hit, e.slot, e.status, rsp.hit, rsp.slot, rsp.status);
					end
				end
			end
			if (hold_off > 0) begin
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 11) == 0) begin
				recv_gap <= $urandom_range(1, 15);
				rsp.ready <= 1'b0;
			end else rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_op(logic [1:0] op, logic [31:0] key, logic [15:0] pay);
		pending_ops.push_back(arc_op_t'{op, key, pay});
	endtask

	task automatic drain_all();
		while (pending_ops.size() != 0 || req.valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		cfg.valid <= 1'b1; cfg.index <= idx; cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_CAPACITY) cap_bytes = val; else ovh_bytes = val[7:0];
	endtask

	// pool of keys keeps hits and ghost hits frequent
	task automatic random_phase(int n, int unsigned pool, int unsigned maxpay);
		for (int i = 0; i < n; i++) begin
			logic [31:0] k;
			int unsigned r;
			r = $urandom_range(0, 99);
			k = (r < 95) ? 32'($urandom_range(0, pool - 1)) : $urandom;
			r = $urandom_range(0, 99);
			if (r < 40) add_op(OP_LOOKUP, k, 16'($urandom));
			else if (r < 70) add_op(OP_INSERT, k,
				$urandom_range(0, 19) == 0 ? 16'($urandom) : 16'($urandom_range(0, maxpay)));
			else if (r < 90) add_op(OP_RELEASE, k, 16'($urandom));
			else add_op(OP_FLUSH, k, 16'($urandom));
		end
	endtask

	initial begin
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(CFG_CAPACITY, 24'd2000);
		write_reg(CFG_OVERHEAD, 24'd255);
		// directed: extremes, all ops, absent keys, duplicates, ghost hits
		add_op(OP_RELEASE, 32'hFFFF_FFFF, 16'h0);
		add_op(OP_FLUSH, 32'h0, 16'hFFFF);
		add_op(OP_LOOKUP, 32'h0, 16'h0);
		add_op(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		add_op(OP_INSERT, 32'h0, 16'h0);
		add_op(OP_INSERT, 32'h0, 16'd100);
		add_op(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0);
		add_op(OP_RELEASE, 32'h0, 16'h0);
		add_op(OP_RELEASE, 32'h0, 16'h0);
		for (int i = 1; i <= 8; i++) add_op(OP_INSERT, 32'(i), 16'd300);
		for (int i = 1; i <= 4; i++) add_op(OP_RELEASE, 32'(i), 16'h0);
		add_op(OP_LOOKUP, 32'd1, 16'h0);
		add_op(OP_INSERT, 32'd1, 16'd5);
		add_op(OP_FLUSH, 32'hFFFF_FFFF, 16'h0);
		drain_all();
		// slot exhaustion with huge capacity and users never released
		write_reg(CFG_CAPACITY, 24'hFF_FFFF);
		write_reg(CFG_OVERHEAD, 24'd1);
		for (int i = 0; i < 70; i++) add_op(OP_INSERT, 32'(1000 + i), 16'($urandom));
		for (int i = 0; i < 40; i++) add_op(OP_FLUSH, 32'(1000 + i), 16'h0);
		drain_all();
		write_reg(CFG_CAPACITY, 24'd1);
		random_phase(150, 24, 20);
		drain_all();
		// long receiver hold-off while the sender keeps offering
		write_reg(CFG_CAPACITY, 24'd3000);
		write_reg(CFG_OVERHEAD, 24'd24);
		hold_off = 600;
		random_phase(700, 40, 200);
		drain_all();
		write_reg(CFG_CAPACITY, 24'd20000);
		write_reg(CFG_OVERHEAD, 24'd128);
		random_phase(600, 80, 600);
		drain_all();
		no_idle = 1'b1;
		write_reg(CFG_CAPACITY, 24'd1500);
		random_phase(300, 30, 100);
		drain_all();
		if (errors == 0 && expected_res.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
